/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent implication check, disabled during reset.
`define CHK_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("check failed");
// Next-cycle implication check, disabled during reset.
`define CHK_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("check failed");
`endif

/* rtl/edf_rr_pkg.sv */
// Package for the EDF scheduler with round-robin fallback.
// Holds word types, request codes and controller states. No dependencies.
`default_nettype none
package edf_rr_pkg;
  localparam int MAX_TASKS = 8;
  localparam int SW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0, REQ_ADD_EDF = 2'd1, REQ_ADD_RING = 2'd2, REQ_DEL_RING = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        yield_flag;
    logic [2:0]  slot;
    logic [15:0] task_id;
    logic [15:0] period;
    logic [15:0] budget;
    logic [7:0]  priority_req;
  } in_word_t;

  typedef struct packed {
    logic        dispatched;
    logic [2:0]  run_slot;
    logic [15:0] run_id;
    logic        from_edf;
    logic        no_task_error;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE, S_REFILL, S_SCAN, S_PICK, S_RING, S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic do_req;
    logic refill;
    logic scan;
    logic pick;
    logic ring;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic scan_last;
  } sts_t;
endpackage
`default_nettype wire

/* rtl/edf_rr_ctrl.sv */
// Controller state machine of the EDF scheduler.
// Depends on edf_rr_pkg.
`default_nettype none
module edf_rr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire edf_rr_pkg::sts_t sts,
  output edf_rr_pkg::cmd_t     cmd
);
  import edf_rr_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (start) state_nxt = S_REFILL;
      S_REFILL: state_nxt = sts.is_tick ? S_SCAN : S_DONE;
      S_SCAN:   if (sts.scan_last) state_nxt = S_PICK;
      S_PICK:   state_nxt = S_RING;
      S_RING:   state_nxt = S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state_r != S_IDLE);
    case (state_r)
      S_IDLE:   cmd.load = start;
      S_REFILL: begin
        cmd.do_req = !sts.is_tick;
        cmd.refill = sts.is_tick;
      end
      S_SCAN:   cmd.scan = 1'b1;
      S_PICK:   cmd.pick = 1'b1;
      S_RING:   cmd.ring = 1'b1;
      S_DONE:   cmd.emit = 1'b1;
      default:  cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

/* rtl/edf_rr_dp.sv */
// Datapath of the EDF scheduler: task tables, ring, serial minimum scan.
// Depends on edf_rr_pkg.
`default_nettype none
module edf_rr_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire edf_rr_pkg::in_word_t in_word,
  input  wire edf_rr_pkg::cmd_t     cmd,
  output edf_rr_pkg::sts_t          sts,
  output logic                      out_strobe,
  output edf_rr_pkg::out_word_t     out_word
);
  import edf_rr_pkg::*;

  in_word_t  req_r;
  logic [31:0] clk_r;
  logic [MAX_TASKS-1:0] ev_r;
  logic [15:0] per_r [MAX_TASKS];
  logic [15:0] bud_r [MAX_TASKS];
  logic [31:0] dl_r  [MAX_TASKS];
  logic [15:0] left_r[MAX_TASKS];
  logic [15:0] eid_r [MAX_TASKS];
  logic [SW-1:0] ord_r [MAX_TASKS];
  logic [CW-1:0] cnt_r;
  logic [15:0] rid_r [MAX_TASKS];
  logic [7:0]  rpr_r [MAX_TASKS];
  logic        lv_r;
  logic [SW-1:0] ls_r;
  logic [7:0]  q_r;
  logic [SW-1:0] idx_r, best_r;
  logic        found_r;
  out_word_t   res_r;
  logic        strobe_r;

  logic [SW-1:0] s;
  logic slot_ok;
  logic [MAX_TASKS-1:0] hit_s, hit_l;
  logic fnd_s, fnd_l;
  logic [SW-1:0] pos_s, pos_l;
  logic cand, better;
  logic cur_ok, rot;
  logic [CW-1:0] cnt_rot;
  logic [SW-1:0] head;

  assign s = req_r.slot[SW-1:0];
  assign slot_ok = ({29'd0, req_r.slot} < 32'(MAX_TASKS));

  always_comb begin
    fnd_s = 1'b0; pos_s = '0; fnd_l = 1'b0; pos_l = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      hit_s[i] = (CW'(i) < cnt_r) && (ord_r[i] == s);
      hit_l[i] = (CW'(i) < cnt_r) && (ord_r[i] == ls_r);
    end
    for (int i = MAX_TASKS-1; i >= 0; i--) begin
      if (hit_s[i]) begin fnd_s = 1'b1; pos_s = SW'(i); end
      if (hit_l[i]) begin fnd_l = 1'b1; pos_l = SW'(i); end
    end
  end

  assign cand = ev_r[idx_r] && (left_r[idx_r] != 16'd0);
  assign better = !found_r || (dl_r[idx_r] < dl_r[best_r]) ||
                  ((dl_r[idx_r] == dl_r[best_r]) && (eid_r[idx_r] < eid_r[best_r]));
  assign cur_ok = lv_r && fnd_l;
  assign rot = req_r.yield_flag || (q_r == 8'd0) || !cur_ok;
  assign cnt_rot = cnt_r;
  assign head = (cur_ok && (pos_l == '0) && (cnt_r > CW'(1))) ? ord_r[1] :
                (cur_ok && (pos_l == '0)) ? ls_r : ord_r[0];

  assign sts.is_tick = (req_r.req_type == REQ_TICK);
  assign sts.scan_last = (idx_r == SW'(MAX_TASKS-1));
  assign out_strobe = strobe_r;
  assign out_word = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_r <= '1; ev_r <= '0; cnt_r <= '0; lv_r <= 1'b0; q_r <= '0;
      strobe_r <= 1'b0; ls_r <= '0;
    end else begin
      strobe_r <= cmd.emit;
      if (cmd.load) req_r <= in_word;
      if (cmd.do_req && slot_ok) begin
        case (req_r.req_type)
          REQ_ADD_EDF: begin
            ev_r[s] <= 1'b1; per_r[s] <= req_r.period; bud_r[s] <= req_r.budget;
            eid_r[s] <= req_r.task_id; dl_r[s] <= clk_r + 32'd1; left_r[s] <= '0;
          end
          REQ_ADD_RING: begin
            rid_r[s] <= req_r.task_id; rpr_r[s] <= req_r.priority_req;
            if (!fnd_s && cnt_r < CW'(MAX_TASKS)) begin
              ord_r[cnt_r[SW-1:0]] <= s; cnt_r <= cnt_r + CW'(1);
            end
          end
          REQ_DEL_RING: if (fnd_s) begin
            for (int i = 0; i < MAX_TASKS-1; i++)
              if (SW'(i) >= pos_s) ord_r[i] <= ord_r[i+1];
            cnt_r <= cnt_r - CW'(1);
          end
          default: ;
        endcase
      end
      if (cmd.load) res_r <= '0;
      if (cmd.refill) begin
        clk_r <= clk_r + 32'd1;
        for (int i = 0; i < MAX_TASKS; i++)
          if (ev_r[i] && dl_r[i] == clk_r + 32'd1) begin
            dl_r[i] <= dl_r[i] + {16'd0, per_r[i]};
            left_r[i] <= bud_r[i];
          end
        idx_r <= '0; found_r <= 1'b0; best_r <= '0;
      end
      if (cmd.scan) begin
        if (cand && better) begin found_r <= 1'b1; best_r <= idx_r; end
        if (!sts.scan_last) idx_r <= idx_r + SW'(1);
      end
      if (cmd.pick && found_r) begin
        left_r[best_r] <= left_r[best_r] - 16'd1;
        res_r <= '{1'b1, 3'(best_r), eid_r[best_r], 1'b1, 1'b0};
      end
      if (cmd.ring && !found_r) begin
        if (rot) begin
          if (cur_ok) begin
            for (int i = 0; i < MAX_TASKS-1; i++)
              if (SW'(i) >= pos_l && CW'(i+1) < cnt_r) ord_r[i] <= ord_r[i+1];
            ord_r[cnt_r[SW-1:0] - SW'(1)] <= ls_r;
          end
          if (cnt_rot == '0) begin
            lv_r <= 1'b0; q_r <= '0;
            res_r <= '{1'b0, 3'd0, 16'd0, 1'b0, 1'b1};
          end else begin
            lv_r <= 1'b1; ls_r <= head;
            q_r <= ((rpr_r[head] != 8'd0) ? rpr_r[head] : 8'd1) - 8'd1;
            res_r <= '{1'b1, 3'(head), rid_r[head], 1'b0, 1'b0};
          end
        end else begin
          q_r <= q_r - 8'd1;
          res_r <= '{1'b1, 3'(ls_r), rid_r[ls_r], 1'b0, 1'b0};
        end
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/edf_with_round_robin_fallback.sv */
// Top level of the EDF scheduler with round-robin fallback.
// Depends on edf_rr_pkg, edf_rr_ctrl and edf_rr_dp.
// Usage:
//   Drive in_word and raise start while busy is low; the word is taken at
//   that edge. One result word follows per request on out_word, marked by
//   out_strobe for one cycle; the receiver cannot stall it.
//   Add and remove requests pass through the refill and done states before
//   the strobe. A tick passes through a refill state, then the minimum-deadline
//   scan walks the table one slot a cycle, then pick, ring and done states.
//   busy falls in the cycle the result is shown, so a new word may be accepted
//   right after; a new word is not taken while one is still in progress.
//   Reset clears all task valid flags, the ring and the clock (all ones, so
//   the first tick reads zero); tables are undefined until written.
`default_nettype none
module edf_with_round_robin_fallback (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire edf_rr_pkg::in_word_t  in_word,
  output logic                       out_strobe,
  output edf_rr_pkg::out_word_t      out_word
);
  import edf_rr_pkg::*;
  cmd_t cmd;
  sts_t sts;

  edf_rr_ctrl u_ctrl (.clk, .rst_n, .start, .busy, .sts, .cmd);
  edf_rr_dp u_dp (.clk, .rst_n, .in_word, .cmd, .sts, .out_strobe, .out_word);
endmodule
`default_nettype wire

/* rtl/edf_rr_checker.sv */
// Port-level checker for the EDF scheduler, bound to the top level.
// Depends on edf_rr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module edf_rr_checker (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  out_strobe,
  input wire edf_rr_pkg::out_word_t out_word
);
  import edf_rr_pkg::*;
  `CHK_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `CHK_NEXT(a_strobe_one, clk, rst_n, out_strobe, !out_strobe)
  `CHK_IMPL(a_err_clean, clk, rst_n, out_strobe && out_word.no_task_error,
            !out_word.dispatched && !out_word.from_edf)
  `CHK_IMPL(a_edf_disp, clk, rst_n, out_strobe && out_word.from_edf, out_word.dispatched)
  `CHK_IMPL(a_idle_quiet, clk, rst_n, out_strobe, !busy)
endmodule

bind edf_with_round_robin_fallback edf_rr_checker u_chk (.*);
`default_nettype wire
